// ----- rtl/xtea_pkg.sv -----
package xtea_pkg;

    localparam int WORD_W = 32;
    localparam int KEY_WORDS = 4;
    localparam int KEY_SEL_W = 2;
    localparam int CFG_INDEX_W = 8;
    localparam int ROUNDS_DEFAULT = 32;

    localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

    localparam logic [CFG_INDEX_W-1:0] KEY_WORD_0 = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] KEY_WORD_1 = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] KEY_WORD_2 = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] KEY_WORD_3 = 8'd3;

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

    typedef struct packed {
        logic              valid;
        logic              cmd;
        logic [WORD_W-1:0] sum;
        logic [WORD_W-1:0] v0;
        logic [WORD_W-1:0] v1;
    } cell_data_t;

endpackage

// ----- rtl/xtea_cell.sv -----
module xtea_cell #(
    parameter bit FIRST_HALF = 1'b1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  xtea_pkg::key_t      key,
    input  xtea_pkg::cell_data_t d_in,
    output xtea_pkg::cell_data_t d_out
);

    logic                           valid_reg;
    logic                           cmd_reg;
    logic [xtea_pkg::WORD_W-1:0]    sum_reg;
    logic [xtea_pkg::WORD_W-1:0]    v0_reg;
    logic [xtea_pkg::WORD_W-1:0]    v1_reg;

    logic                           upd_v0;
    logic [xtea_pkg::WORD_W-1:0]    src;
    logic [xtea_pkg::WORD_W-1:0]    tgt;
    logic [xtea_pkg::KEY_SEL_W-1:0] key_sel;
    logic [xtea_pkg::WORD_W-1:0]    mix;
    logic [xtea_pkg::WORD_W-1:0]    round_key;
    logic [xtea_pkg::WORD_W-1:0]    feist;
    logic [xtea_pkg::WORD_W-1:0]    tgt_next;
    logic [xtea_pkg::WORD_W-1:0]    sum_next;

    // Encryption updates v0 in the first half-round, decryption v1.
    always_comb begin
        upd_v0    = d_in.cmd ^ FIRST_HALF;
        src       = upd_v0 ? d_in.v1 : d_in.v0;
        tgt       = upd_v0 ? d_in.v0 : d_in.v1;
        key_sel   = upd_v0 ? d_in.sum[1:0] : d_in.sum[12:11];
        mix       = ((src << 4) ^ (src >> 5)) + src;
        round_key = d_in.sum + key[key_sel];
        feist     = mix ^ round_key;
        tgt_next  = (d_in.cmd == xtea_pkg::CMD_DECRYPT) ? tgt - feist : tgt + feist;
        if (!FIRST_HALF) begin
            sum_next = d_in.sum;
        end else if (d_in.cmd == xtea_pkg::CMD_DECRYPT) begin
            sum_next = d_in.sum - xtea_pkg::DELTA;
        end else begin
            sum_next = d_in.sum + xtea_pkg::DELTA;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= d_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            cmd_reg <= d_in.cmd;
            sum_reg <= sum_next;
            v0_reg  <= upd_v0 ? tgt_next : d_in.v0;
            v1_reg  <= upd_v0 ? d_in.v1 : tgt_next;
        end
    end

    assign d_out.valid = valid_reg;
    assign d_out.cmd   = cmd_reg;
    assign d_out.sum   = sum_reg;
    assign d_out.v0    = v0_reg;
    assign d_out.v1    = v1_reg;

endmodule

// ----- rtl/xtea_block_cipher.sv -----
// XTEA block cipher, one 64-bit block per beat, ECB.
// Input channel s_: s_command (0 encrypt, 1 decrypt), s_block_first and
// s_block_second carry one block. Output channel m_: m_result_first and
// m_result_second carry the processed block, one result beat per input beat.
// Configuration channel cfg_: cfg_index 0 to 3 writes key words 0 to 3 with
// cfg_data; other indexes are ignored. Keys are to be changed only while
// idle; the block itself does not enforce this. Each half-round is one cell
// of a chain of 2*ROUNDS cells, so a block may enter on every cycle while
// s_ready is high. Each result passes through the cell chain and then the
// output register before it appears on m_valid.
// When the receiver stalls, the output register holds its beat and a skid
// register catches the beat leaving the chain; the chain and s_ready stop
// only while the skid register is full, and resume the cycle after it drains.
// Reset clears all valid flags and sets the four key words to zero.
module xtea_block_cipher #(
    parameter int ROUNDS = xtea_pkg::ROUNDS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_command,
    input  logic [xtea_pkg::WORD_W-1:0]        s_block_first,
    input  logic [xtea_pkg::WORD_W-1:0]        s_block_second,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [xtea_pkg::WORD_W-1:0]        m_result_first,
    output logic [xtea_pkg::WORD_W-1:0]        m_result_second,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [xtea_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [xtea_pkg::WORD_W-1:0]        cfg_data
);

    localparam int CELLS = 2 * ROUNDS;
    localparam logic [63:0] DEC_PRODUCT = 64'(ROUNDS) * 64'(xtea_pkg::DELTA);
    localparam logic [xtea_pkg::WORD_W-1:0] DEC_SUM = DEC_PRODUCT[31:0];

    xtea_pkg::key_t                  key_reg;
    xtea_pkg::cell_data_t            chain [CELLS+1];

    logic                            advance;
    logic                            pipe_arrive;
    logic                            out_load;
    logic                            m_valid_reg;
    logic [xtea_pkg::WORD_W-1:0]     res_first_reg;
    logic [xtea_pkg::WORD_W-1:0]     res_second_reg;
    logic                            skid_valid_reg;
    logic [xtea_pkg::WORD_W-1:0]     skid_first_reg;
    logic [xtea_pkg::WORD_W-1:0]     skid_second_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                xtea_pkg::KEY_WORD_0: key_reg[0] <= cfg_data;
                xtea_pkg::KEY_WORD_1: key_reg[1] <= cfg_data;
                xtea_pkg::KEY_WORD_2: key_reg[2] <= cfg_data;
                xtea_pkg::KEY_WORD_3: key_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign advance = !skid_valid_reg;
    assign s_ready = advance;

    always_comb begin
        chain[0].valid = s_valid;
        chain[0].cmd   = s_command;
        chain[0].sum   = (s_command == xtea_pkg::CMD_DECRYPT) ? DEC_SUM : '0;
        chain[0].v0    = s_block_first;
        chain[0].v1    = s_block_second;
    end

    for (genvar i = 0; i < CELLS; i++) begin : g_cell
        xtea_cell #(
            .FIRST_HALF((i % 2) == 0)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .key     (key_reg),
            .d_in    (chain[i]),
            .d_out   (chain[i+1])
        );
    end

    assign pipe_arrive = advance && chain[CELLS].valid;
    assign out_load    = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= skid_valid_reg || pipe_arrive;
            end
            if (skid_valid_reg) begin
                if (out_load) begin
                    skid_valid_reg <= 1'b0;
                end
            end else if (pipe_arrive && !out_load) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            res_first_reg  <= skid_valid_reg ? skid_first_reg : chain[CELLS].v0;
            res_second_reg <= skid_valid_reg ? skid_second_reg : chain[CELLS].v1;
        end
        if (!skid_valid_reg && pipe_arrive && !out_load) begin
            skid_first_reg  <= chain[CELLS].v0;
            skid_second_reg <= chain[CELLS].v1;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_result_first  = res_first_reg;
    assign m_result_second = res_second_reg;

`ifndef NO_ASSERTIONS
    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("Skid register holds a beat while the output register is empty.");

    a_stall_fills_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (pipe_arrive && !out_load) |=> skid_valid_reg)
        else $error("A beat leaving the cell chain during a stall was not caught.");

    a_key_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_index == xtea_pkg::KEY_WORD_0) |=> key_reg[0] == $past(cfg_data))
        else $error("Key word 0 was not updated by its configuration write.");
`endif

endmodule

// ----- sim/xtea_block_cipher_tb.sv -----
`timescale 1ns / 1ps

module xtea_block_cipher_tb;
    import xtea_pkg::*;

    localparam int CIPHER_CYCLES = ROUNDS_DEFAULT;
    localparam int PIPE_LATENCY = 2 * CIPHER_CYCLES + 1;
    localparam int SETTLE_CYCLES = PIPE_LATENCY + 10;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 5000;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_FIRST = KEY_WORD_3 + 1'b1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LAST = '1;

    typedef struct packed {
        logic              command;
        logic [WORD_W-1:0] first_word;
        logic [WORD_W-1:0] second_word;
    } block_beat_t;

    typedef struct packed {
        logic [WORD_W-1:0] first_word;
        logic [WORD_W-1:0] second_word;
    } cipher_block_t;

    localparam int DIRECTED_COUNT = 16;
    localparam block_beat_t DIRECTED_BEATS [DIRECTED_COUNT] = '{
        {CMD_ENCRYPT, 32'h0000_0000, 32'h0000_0000},
        {CMD_DECRYPT, 32'h0000_0000, 32'h0000_0000},
        {CMD_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
        {CMD_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
        {CMD_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF},
        {CMD_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000},
        {CMD_ENCRYPT, 32'h8000_0000, 32'h0000_0001},
        {CMD_DECRYPT, 32'h0000_0001, 32'h8000_0000},
        {CMD_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555},
        {CMD_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA},
        {CMD_ENCRYPT, 32'h4142_4344, 32'h4546_4748},
        {CMD_DECRYPT, 32'h497D_F3D0, 32'h7261_2CB5},
        {CMD_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF},
        {CMD_DECRYPT, 32'hFEDC_BA98, 32'h7654_3210},
        {CMD_ENCRYPT, 32'h0000_0001, 32'h0000_0000},
        {CMD_DECRYPT, 32'h0000_0000, 32'h8000_0000}
    };

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_command = CMD_ENCRYPT;
    logic [WORD_W-1:0] s_block_first = '0;
    logic [WORD_W-1:0] s_block_second = '0;

    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [WORD_W-1:0] m_result_first;
    logic [WORD_W-1:0] m_result_second;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]      cfg_data = '0;

    logic [WORD_W-1:0] key_words [KEY_WORDS] = '{default: '0};

    block_beat_t   pending_blocks [$];
    cipher_block_t expected_blocks [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_requests = 0;
    int hold_off_served = 0;
    int stall_left = 0;
    int idle_cycles = 0;

    int failures = 0;
    int results_checked = 0;
    int blocks_encrypted = 0;
    int blocks_decrypted = 0;
    int key_settings = 1;
    int input_stall_cycles = 0;

    xtea_block_cipher #(
        .ROUNDS(CIPHER_CYCLES)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_command(s_command),
        .s_block_first(s_block_first),
        .s_block_second(s_block_second),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_result_first(m_result_first),
        .m_result_second(m_result_second),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [WORD_W-1:0] feistel_mix(input logic [WORD_W-1:0] v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

    function automatic cipher_block_t xtea_cipher(input logic command,
                                                  input logic [WORD_W-1:0] v0_in,
                                                  input logic [WORD_W-1:0] v1_in);
        logic [WORD_W-1:0] v0;
        logic [WORD_W-1:0] v1;
        logic [WORD_W-1:0] sum;
        v0 = v0_in;
        v1 = v1_in;
        sum = '0;
        if (command == CMD_ENCRYPT) begin
            for (int i = 0; i < CIPHER_CYCLES; i++) begin
                v0 += feistel_mix(v1) ^ (sum + key_words[sum[1:0]]);
                sum += DELTA;
                v1 += feistel_mix(v0) ^ (sum + key_words[sum[12:11]]);
            end
        end else begin
            repeat (CIPHER_CYCLES) sum += DELTA;
            for (int i = 0; i < CIPHER_CYCLES; i++) begin
                v1 -= feistel_mix(v0) ^ (sum + key_words[sum[12:11]]);
                sum -= DELTA;
                v0 -= feistel_mix(v1) ^ (sum + key_words[sum[1:0]]);
            end
        end
        return '{first_word: v0, second_word: v1};
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return WORD_W'(1) << $urandom_range(WORD_W - 1);
            default: return $urandom;
        endcase
    endfunction

    // Called at a rising edge. Keys first, then one write to an unmapped index.
    task automatic load_key(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
                            input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3,
                            input logic [CFG_INDEX_W-1:0] spare_index,
                            input logic [WORD_W-1:0] spare_data);
        logic [CFG_INDEX_W-1:0] indexes [5];
        logic [WORD_W-1:0]      values [5];
        indexes = '{KEY_WORD_0, KEY_WORD_1, KEY_WORD_2, KEY_WORD_3, spare_index};
        values = '{k0, k1, k2, k3, spare_data};
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= indexes[i];
            cfg_data <= values[i];
            do @(posedge aclk); while (!(cfg_valid && cfg_ready));
            if (indexes[i] < KEY_WORDS) begin
                key_words[indexes[i][KEY_SEL_W-1:0]] = values[i];
            end
        end
        cfg_valid <= 1'b0;
        key_settings++;
    endtask

    task automatic queue_random_blocks(input int count);
        block_beat_t   beat;
        cipher_block_t turned;
        int            queued;
        queued = 0;
        while (queued < count) begin
            beat.command = $urandom_range(1) ? CMD_DECRYPT : CMD_ENCRYPT;
            beat.first_word = pick_word();
            beat.second_word = pick_word();
            pending_blocks.push_back(beat);
            queued++;
            // A quarter of the blocks are followed by the inverse operation on their own
            // result, so decryption also sees real ciphertext.
            if ($urandom_range(3) == 0) begin
                turned = xtea_cipher(beat.command, beat.first_word, beat.second_word);
                beat.command = (beat.command == CMD_ENCRYPT) ? CMD_DECRYPT : CMD_ENCRYPT;
                beat.first_word = turned.first_word;
                beat.second_word = turned.second_word;
                pending_blocks.push_back(beat);
                queued++;
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_blocks.size() != 0 || s_valid || expected_blocks.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (s_valid && s_ready) begin
            expected_blocks.push_back(xtea_cipher(s_command, s_block_first, s_block_second));
            if (s_command == CMD_ENCRYPT) begin
                blocks_encrypted++;
            end else begin
                blocks_decrypted++;
            end
        end
        if (s_valid && !s_ready) begin
            input_stall_cycles++;
        end
        if (!s_valid || s_ready) begin
            if (aresetn && pending_blocks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_command <= pending_blocks[0].command;
                s_block_first <= pending_blocks[0].first_word;
                s_block_second <= pending_blocks[0].second_word;
                void'(pending_blocks.pop_front());
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        cipher_block_t want;
        if (m_valid && m_ready) begin
            if (expected_blocks.size() == 0) begin
                $error("result beat with no block outstanding: %h %h",
                       m_result_first, m_result_second);
                failures++;
            end else begin
                want = expected_blocks.pop_front();
                if (m_result_first !== want.first_word) begin
                    $error("result_first: expected %h, got %h", want.first_word, m_result_first);
                    failures++;
                end
                if (m_result_second !== want.second_word) begin
                    $error("result_second: expected %h, got %h",
                           want.second_word, m_result_second);
                    failures++;
                end
                results_checked++;
            end
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (hold_off_served != hold_off_requests) begin
            hold_off_served <= hold_off_requests;
            stall_left <= HOLD_OFF_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $error("no beat moved on any channel for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The key is all zeros out of reset.
        foreach (DIRECTED_BEATS[i]) pending_blocks.push_back(DIRECTED_BEATS[i]);
        wait_drained();

        load_key('1, '1, '1, '1, CFG_SPARE_FIRST, '0);
        queue_random_blocks(250);
        wait_drained();

        load_key($urandom, $urandom, $urandom, $urandom, CFG_SPARE_LAST, $urandom);
        send_idle_pct = 88;
        recv_stall_pct = 0;
        queue_random_blocks(300);
        wait_drained();

        load_key($urandom, $urandom, $urandom, $urandom, CFG_SPARE_FIRST, $urandom);
        send_idle_pct = 0;
        recv_stall_pct = 88;
        queue_random_blocks(300);
        wait_drained();

        load_key($urandom, $urandom, $urandom, $urandom, CFG_SPARE_LAST, '1);
        send_idle_pct = 32;
        recv_stall_pct = 32;
        queue_random_blocks(500);
        hold_off_requests++;
        wait_drained();

        load_key('0, '1, 32'h8000_0001, $urandom, CFG_SPARE_FIRST, '1);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        queue_random_blocks(350);
        wait_drained();

        if (expected_blocks.size() != 0) begin
            $error("%0d result beats never arrived", expected_blocks.size());
            failures++;
        end
        $display("Ran %0d encrypt and %0d decrypt blocks under %0d keys; %0d results checked.",
                 blocks_encrypted, blocks_decrypted, key_settings, results_checked);
        $display("Input back-pressure was seen on %0d cycles; %0d mismatches.",
                 input_stall_cycles, failures);
        if (failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
